>>> rtl/core/bces_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bces_pkg: shared definitions of the blink error code sequencer
// Field widths, operation codes and the item type passed between stages.
// ----------------------------------------------------------------------------
package bces_pkg;

  // Widths of the item fields on the ports.
  localparam int CODE_W = 4;
  localparam int PASS_W = 8;

  // Default number of code bits kept inside the sequencer.
  localparam int CODE_BITS_DEF = 4;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // One input item as held in the input register.
  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
  } item_t;

endpackage

>>> rtl/core/bces_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bces_in_reg: input register stage
// Captures one item and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module bces_in_reg
  import bces_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  output logic  held_valid,
  output item_t held_item,
  input  logic  take
);

  logic load;

  // The register can load when it is empty or its item leaves this cycle.
  assign load     = !held_valid || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

>>> rtl/core/bces_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bces_update: sequencer state update and result register
// Applies one item to the sequencer state; the state registers are the result.
// ----------------------------------------------------------------------------
module bces_update
  import bces_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              held_valid,
  input  item_t             held_item,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              led_on,
  output logic              running,
  output logic [CODE_W-1:0] active_code,
  output logic [PASS_W-1:0] passes
);

  localparam int SLOT_W = CODE_BITS + 1;

  logic [CODE_BITS-1:0] active_error, active_error_next;
  logic [SLOT_W-1:0]    slot_count, slot_count_next;
  logic [PASS_W-1:0]    pass_count, pass_count_next;
  logic                 stop_pending, stop_pending_next;
  logic                 timer_active, timer_active_next;
  logic                 led_level, led_level_next;
  logic [CODE_BITS-1:0] req;
  logic                 last_slot;

  // The state only moves when the result register is free to show it.
  assign take = held_valid && (!out_valid || !out_stall);

  assign req       = CODE_BITS'(held_item.code);
  assign last_slot = (slot_count == {active_error, 1'b1});

  always_comb begin
    active_error_next = active_error;
    slot_count_next   = slot_count;
    pass_count_next   = pass_count;
    stop_pending_next = stop_pending;
    timer_active_next = timer_active;
    led_level_next    = led_level;
    case (held_item.op)
      OP_SET: begin
        if (active_error == '0 && req != '0) begin
          active_error_next = req;
          slot_count_next   = '0;
          pass_count_next   = '0;
          stop_pending_next = 1'b0;
          led_level_next    = 1'b0;
          timer_active_next = 1'b1;
        end else if (active_error != '0 && req == '0) begin
          stop_pending_next = 1'b1;
        end
      end
      OP_TICK: begin
        if (timer_active) begin
          if (last_slot) begin
            // End of the pass: the LED stays dark.
            slot_count_next = '0;
            if (stop_pending) begin
              timer_active_next = 1'b0;
              active_error_next = '0;
            end else begin
              pass_count_next = pass_count + PASS_W'(1);
            end
          end else begin
            led_level_next  = slot_count[0];
            slot_count_next = slot_count + SLOT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_error <= '0;
      slot_count   <= '0;
      pass_count   <= '0;
      stop_pending <= 1'b0;
      timer_active <= 1'b0;
      led_level    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        active_error <= active_error_next;
        slot_count   <= slot_count_next;
        pass_count   <= pass_count_next;
        stop_pending <= stop_pending_next;
        timer_active <= timer_active_next;
        led_level    <= led_level_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign led_on      = led_level;
  assign running     = timer_active;
  assign active_code = CODE_W'(active_error);
  assign passes      = pass_count;

endmodule

>>> rtl/core/blink_error_code_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blink_error_code_sequencer_unit: LED blink code sequencer
// Shows an error code as a repeating series of LED blinks driven by ticks.
// ----------------------------------------------------------------------------
// Each accepted item gives exactly one result item once the update stage
// takes it, and a new item can be accepted in every cycle while the output is
// not stalled: an input register feeds a single update stage whose state
// registers double as the result register. A set item (op 0) with a nonzero
// code starts a sequence when no code is active; while a code is active,
// nonzero codes are ignored and code zero asks the sequence to stop at the
// end of its current pass. Each tick item (op 1) while running advances one
// slot of the pass: a code of N blinks uses 2N+2 slots, with the LED lit on the
// odd slots but the last one and dark on all the others. The result item shows
// the LED level, the running flag, the active code and the completed pass
// count after the item was applied. CODE_BITS sets how many bits of the
// requested code are kept; higher code bits are dropped.
// ----------------------------------------------------------------------------
module blink_error_code_sequencer_unit
  import bces_pkg::*;
#(
  parameter int CODE_BITS = CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [CODE_W-1:0] code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              led_on,
  output logic              running,
  output logic [CODE_W-1:0] active_code,
  output logic [PASS_W-1:0] passes
);

  item_t in_item;
  item_t held_item;
  logic  held_valid;
  logic  take;

  assign in_item.op   = op_t'(op);
  assign in_item.code = code;

  // The input register holds one item until the update stage takes it.
  bces_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  // The update stage applies the item and presents the new state as a result.
  bces_update #(
    .CODE_BITS (CODE_BITS)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .held_item   (held_item),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_on      (led_on),
    .running     (running),
    .active_code (active_code),
    .passes      (passes)
  );

endmodule

>>> verif/blink_error_code_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blink_error_code_sequencer_unit_tb: self-checking bench of the blink sequencer
// A queued driver feeds set and tick items through the valid/stall input while
// a monitor stalls the output at random and checks every result item against
// a cycle-free model of the blink sequence kept inside the bench.
// ----------------------------------------------------------------------------
module blink_error_code_sequencer_unit_tb;
  import bces_pkg::*;

  // Result of one item as the sequencer should report it.
  typedef struct {
    logic              led;
    logic              run;
    logic [CODE_W-1:0] code;
    logic [PASS_W-1:0] passes;
  } blink_status_t;

  // One pending stimulus item. When drain is set the driver holds the item
  // back until every outstanding result has come out of the block.
  typedef struct {
    op_t               op;
    logic [CODE_W-1:0] code;
    bit                drain;
  } blink_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = OP_SET;
  logic [CODE_W-1:0] code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              led_on;
  logic              running;
  logic [CODE_W-1:0] active_code;
  logic [PASS_W-1:0] passes;

  blink_req_t    req_queue[$];
  blink_status_t status_queue[$];
  int            error_count = 0;
  int            cycle_count = 0;

  // Copy of the sequencer state used to work out the expected status.
  logic [CODE_BITS_DEF-1:0] shown_code = '0;
  int                       slot_idx = 0;
  logic [PASS_W-1:0]        pass_total = '0;
  logic                     stop_req = 1'b0;
  logic                     blinking = 1'b0;
  logic                     lamp = 1'b0;

  blink_error_code_sequencer_unit uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .code        (code),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_on      (led_on),
    .running     (running),
    .active_code (active_code),
    .passes      (passes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one accepted item to the bench copy of the state and queues the
  // status the block has to report for it.
  task automatic advance_blink(input op_t kind, input logic [CODE_W-1:0] value);
    logic [CODE_BITS_DEF-1:0] want;
    int                       span;
    blink_status_t            st;
    want = value[CODE_BITS_DEF-1:0];
    if (kind == OP_SET) begin
      // A nonzero code while busy and a cancel while idle both do nothing.
      if (shown_code == '0 && want != '0) begin
        shown_code = want;
        pass_total = '0;
        slot_idx   = 0;
        stop_req   = 1'b0;
        lamp       = 1'b0;
        blinking   = 1'b1;
      end else if (shown_code != '0 && want == '0) begin
        // Cancel: let the current pass run out first.
        stop_req = 1'b1;
      end
    end else if (blinking) begin
      span = 2 * int'(shown_code);
      // The last slot of a pass keeps the LED as it was, which is dark.
      if (slot_idx < span + 1) lamp = slot_idx[0];
      slot_idx++;
      if (slot_idx == span + 2) begin
        slot_idx = 0;
        if (stop_req) begin
          blinking   = 1'b0;
          shown_code = '0;
        end else begin
          pass_total = pass_total + 1'b1;
        end
      end
    end
    st.led    = lamp;
    st.run    = blinking;
    st.code  = CODE_W'(shown_code);
    st.passes = pass_total;
    status_queue.push_back(st);
  endtask

  task automatic queue_req(input op_t kind, input logic [CODE_W-1:0] value,
                           input bit drain);
    blink_req_t r;
    r.op    = kind;
    r.code  = value;
    r.drain = drain;
    req_queue.push_back(r);
  endtask

  task automatic queue_ticks(input int n);
    for (int i = 0; i < n; i++) queue_req(OP_TICK, CODE_W'($urandom), 1'b0);
  endtask

  // Random idling on both sides, except in one quiet window where the block
  // is fed and drained at full rate.
  function automatic bit idle_now();
    if (cycle_count >= 400 && cycle_count < 700) return 1'b0;
    return $urandom_range(0, 99) < 21;
  endfunction

  // Driver: an item is taken when valid is high and stall is low at the edge.
  // A stalled item stays on the port unchanged; otherwise the next one is
  // presented unless the driver idles or a drain item waits for the block
  // to empty.
  always @(posedge clk) begin : driver
    blink_req_t nxt;
    bit         hold;
    cycle_count = cycle_count + 1;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_blink(op_t'(op), code);
      hold = in_valid && in_stall;
      if (!hold) begin
        if (req_queue.size() > 0 && !idle_now() &&
            !(req_queue[0].drain && status_queue.size() != 0)) begin
          nxt = req_queue.pop_front();
          op       <= nxt.op;
          code     <= nxt.code;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result taken from the block is matched against the oldest
  // expected status, field by field. The output stall is chosen at random.
  always @(posedge clk) begin : monitor
    blink_status_t exp_st;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_queue.size() == 0) begin
          $error("result item with no expected status waiting");
          error_count++;
        end else begin
          exp_st = status_queue.pop_front();
          if (led_on !== exp_st.led) begin
            $error("led_on: expected %0d, actual %0d", exp_st.led, led_on);
            error_count++;
          end
          if (running !== exp_st.run) begin
            $error("running: expected %0d, actual %0d", exp_st.run, running);
            error_count++;
          end
          if (active_code !== exp_st.code) begin
            $error("active_code: expected %0d, actual %0d", exp_st.code, active_code);
            error_count++;
          end
          if (passes !== exp_st.passes) begin
            $error("passes: expected %0d, actual %0d", exp_st.passes, passes);
            error_count++;
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  // Stimulus and end of the run.
  initial begin : stimulus
    int          blinks;
    int          ticks;
    bit          long_done;
    logic [CODE_W-1:0] noise;

    // Directed part. Ticks before any start and a cancel while idle change
    // nothing; a repeat of the running code and another code are both
    // ignored while busy.
    queue_req(OP_TICK, 4'hF, 1'b0);
    queue_req(OP_SET, 4'h0, 1'b0);
    queue_req(OP_SET, 4'h1, 1'b0);
    queue_req(OP_SET, 4'h1, 1'b0);
    queue_req(OP_SET, 4'hF, 1'b0);
    // One whole pass of a single blink: dark, lit, dark, dark, then wrap.
    queue_ticks(4);
    // Cancel twice mid-sequence; the pass still runs to its end and the
    // pass count is kept when the code clears.
    queue_req(OP_SET, 4'h0, 1'b0);
    queue_req(OP_SET, 4'h0, 1'b0);
    queue_ticks(4);
    queue_req(OP_TICK, 4'h0, 1'b0);
    // Largest code, started from idle, with a cancel early in its pass.
    queue_req(OP_SET, 4'hF, 1'b0);
    queue_ticks(4);
    queue_req(OP_SET, 4'h0, 1'b0);
    queue_ticks(3);

    // Random part: mostly well-formed start / blink / cancel sequences with
    // random codes, sprinkled with busy sets, stray cancels and sequences
    // that are never cancelled. One long single-blink run keeps the block
    // busy for twenty passes. The queue is filled before the first clock, so
    // its size is the number of items sent.
    long_done = 1'b0;
    while (req_queue.size() < 1050 || !long_done) begin
      if (!long_done && req_queue.size() > 300) begin
        // Finish whatever runs, then blink once per pass for twenty passes.
        queue_req(OP_SET, 4'h0, 1'b1);
        queue_ticks(32);
        queue_req(OP_SET, 4'h1, 1'b0);
        queue_ticks(20 * 4 + 2);
        queue_req(OP_SET, 4'h0, 1'b0);
        queue_ticks(4);
        long_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: blinks = $urandom_range(1, 4);
        6, 7, 8: blinks = $urandom_range(5, 14);
        default: blinks = 15;
      endcase
      queue_req(OP_SET, CODE_W'(blinks), $urandom_range(0, 49) == 0);
      ticks = $urandom_range(0, 2) * (2 * blinks + 2) + $urandom_range(0, 2 * blinks + 1);
      for (int i = 0; i < ticks; i++) begin
        if ($urandom_range(0, 99) < 4) begin
          noise = CODE_W'($urandom);
          queue_req(OP_SET, noise, 1'b0);
        end
        queue_req(OP_TICK, CODE_W'($urandom), 1'b0);
      end
      if ($urandom_range(0, 99) < 85) begin
        queue_req(OP_SET, 4'h0, 1'b0);
        queue_ticks(2 * blinks + 2);
        // A few ticks after the stop land on a stopped timer.
        queue_ticks($urandom_range(0, 2));
      end
    end

    // Wait out reset, then for all items to go in and all results to come.
    while (rst) @(posedge clk);
    while (req_queue.size() != 0 || in_valid || status_queue.size() != 0)
      @(posedge clk);
    // Leave some margin for any stray result to show up.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Reset is held at the start of the run and then released.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/bces_pkg.sv
rtl/core/bces_in_reg.sv
rtl/core/bces_update.sv
rtl/core/blink_error_code_sequencer_unit.sv
verif/blink_error_code_sequencer_unit_tb.sv
